// File: hw/rtl/view_cache_coherence_directory_core_assert.svh
// assertion helpers for the directory core
`ifndef VIEW_CACHE_COHERENCE_DIRECTORY_CORE_ASSERT_SVH
`define VIEW_CACHE_COHERENCE_DIRECTORY_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("directory core check failed");

// next-cycle implication, checked outside reset
`define VCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("directory core check failed");

`endif

// File: hw/rtl/vccd_pkg.sv
package vccd_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int KEY_BITS_DEF    = 48;
    localparam int LOCK_BITS_DEF   = 16;
    localparam int SIZE_W          = 48;
    localparam int INDEX_W         = 7;
    localparam int CFG_W           = 8;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd32;

    typedef enum logic [1:0] {
        OP_DEV_OPEN   = 2'd0,
        OP_HOST_OPEN  = 2'd1,
        OP_DEV_CLOSE  = 2'd2,
        OP_HOST_CLOSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_DISCARD = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        COH_EMPTY      = 2'd0,
        COH_CPUDIRTY   = 2'd1,
        COH_CONSISTENT = 2'd2,
        COH_ACCDIRTY   = 2'd3
    } coh_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_CONFLICT  = 3'd2,
        ST_NO_VICTIM = 3'd3,
        ST_SIZE_MISS = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_DECIDE
    } state_t;

endpackage

// File: hw/rtl/view_cache_coherence_directory_core.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | operation, key, size_bytes, access_mode, hint
// m_      | out       | m_valid / m_ready  | entry_index .. new_coherence
// cfg_    | in        | cfg_valid/cfg_ready| active entry count
//
// each item visits every one of the n active entries (n = active entries, 1..MAX_ENTRIES)
// once during the scan, through the single read port of the entry memory; the victim
// pointer is first reduced below n, one wrap at a time, when n has shrunk below it
// aresetn is synchronous: all entries read as empty, lock counts zero, pointer zero
// a result waits in the output register; the next item is taken meanwhile and only
// stalls at its write-back step if the previous result has not yet been taken
module view_cache_coherence_directory_core #(
    parameter int MAX_ENTRIES = vccd_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = vccd_pkg::KEY_BITS_DEF,
    parameter int LOCK_BITS   = vccd_pkg::LOCK_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [vccd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [vccd_pkg::SIZE_W-1:0]  s_size_bytes,
    input  logic [1:0]                   s_access_mode,
    input  logic                         s_transient_hint,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [vccd_pkg::INDEX_W-1:0] m_entry_index,
    output logic [2:0]                   m_status,
    output logic                         m_evicted,
    output logic [KEY_BITS-1:0]          m_evicted_key,
    output logic                         m_flush_before_evict,
    output logic                         m_free_device_buffer,
    output logic                         m_allocate_device_buffer,
    output logic                         m_copy_to_device,
    output logic                         m_copy_from_device,
    output logic [1:0]                   m_new_coherence
);
    import vccd_pkg::*;

    localparam int IW     = $clog2(MAX_ENTRIES);
    localparam int NW     = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (NW > CFG_W) ? NW : CFG_W;
    localparam int KS_W   = KEY_BITS + SIZE_W;
    localparam int META_W = 4 + 2 * LOCK_BITS;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX = {LOCK_BITS{1'b1}};
    localparam logic [CW-1:0] N_MAX = CW'(MAX_ENTRIES);

    // entry memory: key and size in one, coherence state, flags and locks in the other
    // meta layout {coherence, transient, device lock, host lock, allocated}
    logic [KS_W-1:0]   ks_mem   [MAX_ENTRIES];
    logic [META_W-1:0] meta_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] vld_reg;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] active_reg;
    logic [NW-1:0]    n_reg;
    logic [IW-1:0]    vp_reg;     // victim pointer
    logic [IW-1:0]    vpw_reg;    // victim pointer reduced mod n
    logic [IW-1:0]    cnt_reg;

    // latched item
    op_t                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [1:0]         mode_reg;
    logic               hint_reg;

    // scan results
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          vic_ok_reg;
    logic [IW-1:0] vic_idx_reg;
    logic [2:0]    vic_rank_reg;
    logic [NW-1:0] vic_pos_reg;

    // read port
    logic [IW-1:0]     rd_addr;
    logic              rd_en;
    logic              scan_rd;
    logic [KS_W-1:0]   rd_ks_reg;
    logic [META_W-1:0] rd_meta_reg;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_pend_reg;

    // output register
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  o_idx_reg;
    logic [2:0]          o_status_reg;
    logic                o_evicted_reg;
    logic [KEY_BITS-1:0] o_ekey_reg;
    logic                o_flush_reg;
    logic                o_free_reg;
    logic                o_alloc_reg;
    logic                o_cpto_reg;
    logic                o_cpfrom_reg;
    logic [1:0]          o_coh_reg;

    // decoded read data, never-written entries read as empty and unlocked
    logic [1:0]           r_coh;
    logic                 r_tr;
    logic [LOCK_BITS-1:0] r_dl;
    logic [LOCK_BITS-1:0] r_hl;
    logic                 r_al;
    logic [KEY_BITS-1:0]  r_key;
    logic [SIZE_W-1:0]    r_size;

    always_comb begin
        r_key  = rd_ks_reg[KS_W-1 -: KEY_BITS];
        r_size = rd_ks_reg[SIZE_W-1:0];
        if (rd_vld_reg) begin
            {r_coh, r_tr, r_dl, r_hl, r_al} = rd_meta_reg;
        end else begin
            r_coh = COH_EMPTY;
            r_tr  = 1'b0;
            r_dl  = '0;
            r_hl  = '0;
            r_al  = 1'b0;
        end
    end

    // clamp of the register into 1..MAX_ENTRIES
    logic [CW-1:0] act_ext;
    logic [NW-1:0] n_clamp;
    always_comb begin
        act_ext = CW'(active_reg);
        if (act_ext == '0) begin
            n_clamp = NW'(1);
        end else if (act_ext > N_MAX) begin
            n_clamp = NW'(MAX_ENTRIES);
        end else begin
            n_clamp = NW'(act_ext);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    logic accept;
    logic decide_go;
    assign accept    = s_valid && s_ready;
    assign decide_go = (state_reg == S_DECIDE) && !(m_valid_reg && !m_ready);

    logic last_issue;
    assign last_issue = ({1'b0, cnt_reg} == NW'(n_reg - NW'(1)));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_REDUCE;
            end
            S_REDUCE: begin
                if (NW'(vpw_reg) < n_reg) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (last_issue) state_next = S_DRAIN;
            end
            S_DRAIN:  state_next = S_FETCH;
            S_FETCH:  state_next = S_DECIDE;
            S_DECIDE: begin
                if (decide_go) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // read port control
    always_comb begin
        scan_rd = 1'b0;
        rd_en   = 1'b0;
        rd_addr = cnt_reg;
        unique case (state_reg)
            S_SCAN: begin
                scan_rd = 1'b1;
                rd_en   = 1'b1;
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = hit_reg ? hit_idx_reg : vic_idx_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_ks_reg   <= ks_mem[rd_addr];
            rd_meta_reg <= meta_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // scan step: lowest match, and best victim by rank then by visiting position
    logic          s_match;
    logic          s_unlocked;
    logic [2:0]    s_rank;
    logic [NW-1:0] s_pos;
    logic          s_better;
    always_comb begin
        s_match    = (r_coh != COH_EMPTY) && (r_key == key_reg);
        s_unlocked = (r_dl == '0) && (r_hl == '0);
        if (r_coh == COH_EMPTY) begin
            s_rank = 3'd0;
        end else begin
            s_rank = (r_tr ? 3'd0 : 3'd3) + {1'b0, r_coh};
        end
        if (rd_idx_reg >= vpw_reg) begin
            s_pos = NW'(rd_idx_reg - vpw_reg);
        end else begin
            s_pos = NW'(rd_idx_reg) + n_reg - NW'(vpw_reg);
        end
        s_better = !vic_ok_reg || (s_rank < vic_rank_reg)
                || ((s_rank == vic_rank_reg) && (s_pos > vic_pos_reg));
    end

    // write-back decision
    logic                 w_meta_en;
    logic                 w_ks_en;
    logic [IW-1:0]        w_idx;
    logic [1:0]           w_coh;
    logic                 w_tr;
    logic [LOCK_BITS-1:0] w_dl;
    logic [LOCK_BITS-1:0] w_hl;
    logic                 w_al;
    logic                 vp_step;
    logic [IW-1:0]        d_idx;
    status_t              d_status;
    logic                 d_evicted;
    logic [KEY_BITS-1:0]  d_ekey;
    logic                 d_flush;
    logic                 d_free;
    logic                 d_alloc;
    logic                 d_cpto;
    logic                 d_cpfrom;
    logic                 dev;
    logic                 wr;
    logic [LOCK_BITS-1:0] own;
    logic [LOCK_BITS-1:0] other;

    always_comb begin
        w_meta_en = 1'b0;
        w_ks_en   = 1'b0;
        vp_step   = 1'b0;
        w_idx     = hit_reg ? hit_idx_reg : vic_idx_reg;
        w_coh     = r_coh;
        w_tr      = r_tr;
        w_dl      = r_dl;
        w_hl      = r_hl;
        w_al      = r_al;
        d_idx     = hit_reg ? hit_idx_reg : '0;
        d_status  = ST_OK;
        d_evicted = 1'b0;
        d_ekey    = '0;
        d_flush   = 1'b0;
        d_free    = 1'b0;
        d_alloc   = 1'b0;
        d_cpto    = 1'b0;
        d_cpfrom  = 1'b0;
        dev       = (op_reg == OP_DEV_OPEN) || (op_reg == OP_DEV_CLOSE);
        own       = dev ? r_dl : r_hl;
        other     = dev ? r_hl : r_dl;
        wr        = dev ? ((mode_reg == MODE_WRITE) || (mode_reg == MODE_DISCARD))
                        : (mode_reg == MODE_WRITE);
        if ((op_reg == OP_DEV_CLOSE) || (op_reg == OP_HOST_CLOSE)) begin
            if (!hit_reg) begin
                d_status = ST_NOT_FOUND;
            end else if ((other != '0) || (own == '0)) begin
                d_status = ST_CONFLICT;
            end else begin
                w_meta_en = 1'b1;
                if (dev) w_dl = r_dl - LOCK_BITS'(1);
                else     w_hl = r_hl - LOCK_BITS'(1);
            end
        end else begin
            if (hit_reg) begin
                if (other != '0)            d_status = ST_CONFLICT;
                else if (r_size != size_reg) d_status = ST_SIZE_MISS;
                else if (own == LOCK_MAX)    d_status = ST_OVERFLOW;
            end else if (!vic_ok_reg) begin
                d_status = ST_NO_VICTIM;
            end else begin
                // evict the victim and take it over for this key
                d_idx   = vic_idx_reg;
                vp_step = 1'b1;
                w_ks_en = 1'b1;
                if (r_coh != COH_EMPTY) begin
                    d_evicted = 1'b1;
                    d_ekey    = r_key;
                    d_flush   = (r_coh == COH_ACCDIRTY);
                    d_free    = r_al;
                end
                w_coh = COH_EMPTY;
                w_dl  = '0;
                w_hl  = '0;
                w_al  = 1'b0;
            end
            if (d_status == ST_OK) begin
                w_meta_en = 1'b1;
                w_tr      = hint_reg;
                if (dev) begin
                    if ((w_coh == COH_EMPTY) || (w_coh == COH_CPUDIRTY)) begin
                        if (!w_al) begin
                            d_alloc = 1'b1;
                            w_al    = 1'b1;
                        end
                        d_cpto = (mode_reg != MODE_DISCARD);
                        w_coh  = wr ? COH_ACCDIRTY : COH_CONSISTENT;
                    end else if ((w_coh == COH_CONSISTENT) && wr) begin
                        w_coh = COH_ACCDIRTY;
                    end
                    w_dl = w_dl + LOCK_BITS'(1);
                end else begin
                    if (w_coh == COH_EMPTY) begin
                        w_coh = COH_CPUDIRTY;
                    end else if (w_coh == COH_CONSISTENT) begin
                        if (wr) w_coh = COH_CPUDIRTY;
                    end else if (w_coh == COH_ACCDIRTY) begin
                        d_cpfrom = 1'b1;
                        w_coh    = wr ? COH_CPUDIRTY : COH_CONSISTENT;
                    end
                    w_hl = w_hl + LOCK_BITS'(1);
                end
            end
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (decide_go && w_meta_en) begin
            meta_mem[w_idx] <= {w_coh, w_tr, w_dl, w_hl, w_al};
        end
        if (decide_go && w_ks_en) begin
            ks_mem[w_idx] <= {key_reg, size_reg};
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            active_reg   <= ACTIVE_RESET;
            vp_reg       <= '0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            vic_ok_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= scan_rd;
            if (cfg_valid && cfg_ready) active_reg <= cfg_data;
            if (accept) begin
                hit_reg    <= 1'b0;
                vic_ok_reg <= 1'b0;
            end
            if (rd_pend_reg) begin
                if (s_match && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                if (s_unlocked && s_better) begin
                    vic_ok_reg   <= 1'b1;
                    vic_idx_reg  <= rd_idx_reg;
                    vic_rank_reg <= s_rank;
                    vic_pos_reg  <= s_pos;
                end
            end
            if (decide_go) begin
                m_valid_reg <= 1'b1;
                if (w_meta_en) vld_reg[w_idx] <= 1'b1;
                if (vp_step) begin
                    if (NW'(vpw_reg) + NW'(1) == n_reg) vp_reg <= '0;
                    else vp_reg <= vpw_reg + IW'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // reported state: updated state on success, stored state on an error with a match
    function automatic logic [1:0] w_coh_out(input status_t st, input logic [1:0] nc,
                                             input logic [1:0] oc);
        return (st == ST_OK) ? nc : oc;
    endfunction

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_operation);
            key_reg  <= s_key;
            size_reg <= s_size_bytes;
            mode_reg <= s_access_mode;
            hint_reg <= s_transient_hint;
            n_reg    <= n_clamp;
            vpw_reg  <= vp_reg;
            cnt_reg  <= '0;
        end
        if ((state_reg == S_REDUCE) && (NW'(vpw_reg) >= n_reg)) begin
            vpw_reg <= IW'(NW'(vpw_reg) - n_reg);
        end
        if (state_reg == S_SCAN) cnt_reg <= cnt_reg + IW'(1);
        if (decide_go) begin
            o_idx_reg     <= INDEX_W'(d_idx);
            o_status_reg  <= d_status;
            o_evicted_reg <= d_evicted;
            o_ekey_reg    <= d_ekey;
            o_flush_reg   <= d_flush;
            o_free_reg    <= d_free;
            o_alloc_reg   <= d_alloc;
            o_cpto_reg    <= d_cpto;
            o_cpfrom_reg  <= d_cpfrom;
            o_coh_reg     <= (d_status == ST_OK || hit_reg) ? w_coh_out(d_status, w_coh, r_coh)
                                                            : COH_EMPTY;
        end
    end

    assign m_valid                  = m_valid_reg;
    assign m_entry_index            = o_idx_reg;
    assign m_status                 = o_status_reg;
    assign m_evicted                = o_evicted_reg;
    assign m_evicted_key            = o_ekey_reg;
    assign m_flush_before_evict     = o_flush_reg;
    assign m_free_device_buffer     = o_free_reg;
    assign m_allocate_device_buffer = o_alloc_reg;
    assign m_copy_to_device         = o_cpto_reg;
    assign m_copy_from_device       = o_cpfrom_reg;
    assign m_new_coherence          = o_coh_reg;

`include "view_cache_coherence_directory_core_assert.svh"

    `VCD_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg == S_REDUCE)
    `VCD_ASSERT_NOW(a_result_from_decide, aclk, aresetn, $rose(m_valid_reg), $past(decide_go))
    `VCD_ASSERT_NOW(a_write_in_decide, aclk, aresetn, w_meta_en && decide_go, state_reg == S_DECIDE)
    `VCD_ASSERT_NOW(a_scan_within_n, aclk, aresetn, state_reg == S_SCAN, NW'(cnt_reg) < n_reg)

endmodule
